>>> sv/cpr_pkg.sv
// Package for the camera pixel to RGB888 converter.
// Holds register indexes, format codes, reset values, coefficients and shared types.
// No dependencies.
package cpr_pkg;

   // Configuration register indexes
   localparam logic [1:0] CsrFormatMode  = 2'd0;
   localparam logic [1:0] CsrFrameWidth  = 2'd1;
   localparam logic [1:0] CsrFrameHeight = 2'd2;
   localparam int         CsrIndexWidth  = 2;
   localparam int         CsrDataWidth   = 13;

   // Input format codes
   localparam logic FormatRgb565 = 1'b0;
   localparam logic FormatYuyv   = 1'b1;

   // Register reset values
   localparam logic        ResetFormatMode  = FormatYuyv;
   localparam logic [12:0] ResetFrameWidth  = 13'd640;
   localparam logic [12:0] ResetFrameHeight = 13'd480;

   // Frame bounds
   localparam int          DefaultMaxWidth = 4096;
   localparam logic [12:0] MaxHeight       = 13'd4096;
   localparam int          RowWidth        = 12;

   // Fixed-point YUV coefficients (scaled by 256)
   localparam logic signed [9:0] CoefRV = 10'sd359;
   localparam logic signed [9:0] CoefGU = 10'sd88;
   localparam logic signed [9:0] CoefGV = 10'sd183;
   localparam logic signed [9:0] CoefBU = 10'sd454;

   // Per-word position flags
   typedef struct packed {
      logic second_valid;
      logic row_end;
      logic frame_end;
   } flag_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

>>> sv/camera_pixel_to_rgb888_top.sv
// Top level of the camera pixel to RGB888 converter.
// Depends on cpr_pkg.
//
// Takes one word of four raw camera bytes (YUYV 4:2:2 or two little-endian RGB565 pixels)
// every clock while req_ready is high and returns one word with two RGB888 pixels plus
// row and frame markers. Throughput is one word per cycle while req_ready is high. A word
// presented while req_ready is high goes into the input register, then into the result
// register, and then shows with rsp_valid. req_ready drops only while both registers hold
// a word and rsp_ready is low. Column and row counters advance when a word is accepted.
// Configuration may only be written while no word is in flight.
module camera_pixel_to_rgb888_top #(
   parameter int MAX_WIDTH = cpr_pkg::DefaultMaxWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_write,
   input  logic [cpr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [cpr_pkg::CsrDataWidth-1:0]  csr_wdata,
   // input words
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_byte0,
   input  logic [7:0]                       req_byte1,
   input  logic [7:0]                       req_byte2,
   input  logic [7:0]                       req_byte3,
   // result words
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_red0,
   output logic [7:0]                       rsp_green0,
   output logic [7:0]                       rsp_blue0,
   output logic [7:0]                       rsp_red1,
   output logic [7:0]                       rsp_green1,
   output logic [7:0]                       rsp_blue1,
   output logic                             rsp_second_valid,
   output logic                             rsp_row_end,
   output logic                             rsp_frame_end
);

   localparam int PairMax  = (MAX_WIDTH + 1) / 2;
   localparam int ColWidth = (PairMax > 1) ? $clog2(PairMax) : 1;
   localparam int RowWidth = cpr_pkg::RowWidth;

   // ---------------------------------------------------------------- functions
   function automatic logic [7:0] clamp8(input logic signed [10:0] x);
      logic [7:0] res;
      if (x < 11'sd0) begin
         res = 8'd0;
      end else if (x > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   function automatic cpr_pkg::rgb_type yuv_pixel(input logic [7:0] y,
                                                 input logic signed [7:0] u,
                                                 input logic signed [7:0] v);
      logic signed [17:0] pr, pg, pb;
      logic signed [10:0] sy, r, g, b;
      cpr_pkg::rgb_type   res;
      pr = 18'(v) * 18'(cpr_pkg::CoefRV);
      pg = 18'(u) * 18'(cpr_pkg::CoefGU) + 18'(v) * 18'(cpr_pkg::CoefGV);
      pb = 18'(u) * 18'(cpr_pkg::CoefBU);
      sy = signed'({3'b000, y});
      // arithmetic shift gives floor division by 256
      r  = sy + 11'(pr >>> 8);
      g  = sy - 11'(pg >>> 8);
      b  = sy + 11'(pb >>> 8);
      res.red   = clamp8(r);
      res.green = clamp8(g);
      res.blue  = clamp8(b);
      return res;
   endfunction

   function automatic cpr_pkg::rgb_type rgb565_pixel(input logic [15:0] p);
      cpr_pkg::rgb_type res;
      res.red   = {p[15:11], p[15:13]};
      res.green = {p[10:5],  p[10:9]};
      res.blue  = {p[4:0],   p[4:2]};
      return res;
   endfunction

   // ---------------------------------------------------------------- config registers
   logic        format_mode_ff;
   logic [12:0] frame_width_ff;
   logic [12:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff  <= cpr_pkg::ResetFormatMode;
         frame_width_ff  <= cpr_pkg::ResetFrameWidth;
         frame_height_ff <= cpr_pkg::ResetFrameHeight;
      end else if (csr_write) begin
         unique case (csr_index)
            cpr_pkg::CsrFormatMode:  format_mode_ff  <= csr_wdata[0];
            cpr_pkg::CsrFrameWidth:  frame_width_ff  <= csr_wdata;
            cpr_pkg::CsrFrameHeight: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s2_ready;
   logic req_fire;

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------- position counters
   logic [13:0]          width_eff;
   logic [13:0]          pairs;
   logic [12:0]          height_eff;
   logic [ColWidth-1:0]  col_ff, col_in;
   logic [RowWidth-1:0]  row_ff, row_in;
   cpr_pkg::flag_type    flags;

   always_comb begin
      // clamp the width to 1..MAX_WIDTH and the height to 1..MaxHeight
      if (frame_width_ff == 13'd0) begin
         width_eff = 14'd1;
      end else if ({1'b0, frame_width_ff} > 14'(MAX_WIDTH)) begin
         width_eff = 14'(MAX_WIDTH);
      end else begin
         width_eff = {1'b0, frame_width_ff};
      end
      if (frame_height_ff == 13'd0) begin
         height_eff = 13'd1;
      end else if (frame_height_ff > cpr_pkg::MaxHeight) begin
         height_eff = cpr_pkg::MaxHeight;
      end else begin
         height_eff = frame_height_ff;
      end
      pairs = (width_eff + 14'd1) >> 1;

      flags.row_end      = (14'(col_ff) + 14'd1) >= pairs;
      flags.frame_end    = flags.row_end && ((13'(row_ff) + 13'd1) >= height_eff);
      flags.second_valid = !(flags.row_end && width_eff[0]);

      if (flags.row_end) begin
         col_in = '0;
         row_in = flags.frame_end ? '0 : row_ff + RowWidth'(1);
      end else begin
         col_in = col_ff + ColWidth'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- input register
   logic [7:0]        s1_byte0_ff, s1_byte1_ff, s1_byte2_ff, s1_byte3_ff;
   cpr_pkg::flag_type s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte0_ff <= req_byte0;
         s1_byte1_ff <= req_byte1;
         s1_byte2_ff <= req_byte2;
         s1_byte3_ff <= req_byte3;
         s1_flags_ff <= flags;
      end
   end

   // ---------------------------------------------------------------- conversion
   cpr_pkg::rgb_type pix0, pix1;
   logic signed [7:0] chroma_u, chroma_v;

   always_comb begin
      // offset by -128 is a flip of the top bit
      chroma_u = signed'({~s1_byte1_ff[7], s1_byte1_ff[6:0]});
      chroma_v = signed'({~s1_byte3_ff[7], s1_byte3_ff[6:0]});
      if (format_mode_ff == cpr_pkg::FormatYuyv) begin
         pix0 = yuv_pixel(s1_byte0_ff, chroma_u, chroma_v);
         pix1 = yuv_pixel(s1_byte2_ff, chroma_u, chroma_v);
      end else begin
         pix0 = rgb565_pixel({s1_byte1_ff, s1_byte0_ff});
         pix1 = rgb565_pixel({s1_byte3_ff, s1_byte2_ff});
      end
      // pixel past the end of an odd row reads as black
      if (!s1_flags_ff.second_valid) begin
         pix1 = '0;
      end
   end

   // ---------------------------------------------------------------- result register
   cpr_pkg::rgb_type  rsp_pix0_ff, rsp_pix1_ff;
   cpr_pkg::flag_type rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_pix0_ff  <= pix0;
         rsp_pix1_ff  <= pix1;
         rsp_flags_ff <= s1_flags_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red0         = rsp_pix0_ff.red;
   assign rsp_green0       = rsp_pix0_ff.green;
   assign rsp_blue0        = rsp_pix0_ff.blue;
   assign rsp_red1         = rsp_pix1_ff.red;
   assign rsp_green1       = rsp_pix1_ff.green;
   assign rsp_blue1        = rsp_pix1_ff.blue;
   assign rsp_second_valid = rsp_flags_ff.second_valid;
   assign rsp_row_end      = rsp_flags_ff.row_end;
   assign rsp_frame_end    = rsp_flags_ff.frame_end;

endmodule

>>> sv/cpr_checker.sv
// Port-level checks for the camera pixel to RGB888 converter, bound to its top level.
// Depends on camera_pixel_to_rgb888_top.
module cpr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_red0,
   input logic [7:0]                        rsp_green0,
   input logic [7:0]                        rsp_blue0,
   input logic [7:0]                        rsp_red1,
   input logic [7:0]                        rsp_green1,
   input logic [7:0]                        rsp_blue1,
   input logic                              rsp_second_valid,
   input logic                              rsp_row_end,
   input logic                              rsp_frame_end
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a frame ends only at the end of a row
   a_frame_on_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame_end without row_end");

   // a missing second pixel only happens on the last word of a row, and reads as black
   a_half_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_second_valid |->
         rsp_row_end && rsp_red1 == 8'd0 && rsp_green1 == 8'd0 && rsp_blue1 == 8'd0)
      else $error("bad second pixel on odd row end");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red0) && $stable(rsp_green0)
         && $stable(rsp_blue0) && $stable(rsp_red1) && $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind camera_pixel_to_rgb888_top cpr_checker u_cpr_checker (.*);
